// ===== design/lsl_pkg.sv =====
package lsl_pkg;

    typedef logic [30:0] q31_t;

    localparam q31_t Q31_MAX = 31'h7fffffff;

    // configuration register map, byte address is 4 * index
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_THRESHOLD          = 3'd0;
    localparam logic [2:0] REG_MAKEUP_GAIN        = 3'd1;
    localparam logic [2:0] REG_FIXED_RELEASE_COEF = 3'd2;
    localparam logic [2:0] REG_ENVELOPE_ALPHA     = 3'd3;
    localparam logic [2:0] REG_SAMPLE_PERIOD      = 3'd4;
    localparam logic [2:0] REG_MAX_RELEASE_TIME   = 3'd5;
    localparam logic [2:0] REG_AVERAGE_SCALE      = 3'd6;

    localparam q31_t RST_THRESHOLD          = 31'd214748365;
    localparam q31_t RST_MAKEUP_GAIN        = 31'd83885240;
    localparam q31_t RST_FIXED_RELEASE_COEF = 31'd2147037831;
    localparam q31_t RST_ENVELOPE_ALPHA     = 31'd2147259850;
    localparam q31_t RST_SAMPLE_PERIOD      = 31'd44739;
    localparam q31_t RST_MAX_RELEASE_TIME   = 31'd65536;
    localparam q31_t RST_AVERAGE_SCALE      = 31'd65075262;

    typedef struct packed {
        q31_t threshold;
        q31_t makeup_gain;
        q31_t fixed_release_coef;
        q31_t envelope_alpha;
        q31_t sample_period;
        q31_t max_release_time;
        q31_t average_scale;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_AVG1,
        OP_AVG2,
        OP_SQ,
        OP_ENV,
        OP_PEAK,
        OP_RMS,
        OP_TAU,
        OP_FIX_A,
        OP_FIX_B,
        OP_CRS_A,
        OP_CRS_B,
        OP_OUT_L,
        OP_OUT_R,
        OP_MK_L,
        OP_MK_R,
        OP_PUBLISH
    } op_t;

    typedef enum logic [1:0] {
        DIV_GAIN,
        DIV_CF,
        DIV_REL
    } div_sel_t;

    typedef struct packed {
        op_t      op;
        div_sel_t div_sel;
        logic     div_start;
        logic     scan_start;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== design/lsl_if.sv =====
interface lsl_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface lsl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_out;
    logic signed [31:0] right_out;
    logic [30:0]        fixed_gain;
    logic [30:0]        crest_gain_out;
    logic [30:0]        crest_factor;
    logic [30:0]        release_time;
    logic [30:0]        makeup_out;

    modport source (
        output valid, output left_out, output right_out, output fixed_gain,
        output crest_gain_out, output crest_factor, output release_time,
        output makeup_out, input ready
    );
    modport sink (
        input valid, input left_out, input right_out, input fixed_gain,
        input crest_gain_out, input crest_factor, input release_time,
        input makeup_out, output ready
    );
endinterface

// ===== design/lookahead_stereo_limiter.sv =====
// Look-ahead stereo peak limiter. Each transfer on samples carries one Q1.31 pair;
// each transfer on results carries the pair from LOOKAHEAD_LEN items earlier, limited
// by the crest-adaptive release gain and scaled by the makeup gain, with the gains,
// crest factor and release time used for it. One item is processed at a time: a scan of the
// peak window one entry per cycle plus three divisions in a shared bit-serial divider,
// which skips its bit steps when a division saturates. The next item is taken only after
// the result is published; publishing waits while the previous result is still not taken.
// A finished result waits in the output register while the next item is already taken.
// Registers are to be written through the APB port only while no item is in flight; the
// block itself does not enforce this.
module lookahead_stereo_limiter #(
    parameter int LOOKAHEAD_LEN = 64,
    parameter int WINDOW_LEN    = 128,
    parameter int HALF_LEN      = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsl_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    lsl_in_if.sink                            samples,
    lsl_out_if.source                         results
);
    import lsl_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    in_accept;
    logic    wr_en;
    logic [2:0] reg_idx;

    // register file, writes land in the access phase
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold          <= RST_THRESHOLD;
            cfg_reg.makeup_gain        <= RST_MAKEUP_GAIN;
            cfg_reg.fixed_release_coef <= RST_FIXED_RELEASE_COEF;
            cfg_reg.envelope_alpha     <= RST_ENVELOPE_ALPHA;
            cfg_reg.sample_period      <= RST_SAMPLE_PERIOD;
            cfg_reg.max_release_time   <= RST_MAX_RELEASE_TIME;
            cfg_reg.average_scale      <= RST_AVERAGE_SCALE;
        end
        else if (wr_en)
        begin
            // top bit of the data is dropped, addresses past the map are ignored
            case (reg_idx)
                REG_THRESHOLD:          cfg_reg.threshold          <= pwdata[30:0];
                REG_MAKEUP_GAIN:        cfg_reg.makeup_gain        <= pwdata[30:0];
                REG_FIXED_RELEASE_COEF: cfg_reg.fixed_release_coef <= pwdata[30:0];
                REG_ENVELOPE_ALPHA:     cfg_reg.envelope_alpha     <= pwdata[30:0];
                REG_SAMPLE_PERIOD:      cfg_reg.sample_period      <= pwdata[30:0];
                REG_MAX_RELEASE_TIME:   cfg_reg.max_release_time   <= pwdata[30:0];
                REG_AVERAGE_SCALE:      cfg_reg.average_scale      <= pwdata[30:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD:          prdata = {1'b0, cfg_reg.threshold};
            REG_MAKEUP_GAIN:        prdata = {1'b0, cfg_reg.makeup_gain};
            REG_FIXED_RELEASE_COEF: prdata = {1'b0, cfg_reg.fixed_release_coef};
            REG_ENVELOPE_ALPHA:     prdata = {1'b0, cfg_reg.envelope_alpha};
            REG_SAMPLE_PERIOD:      prdata = {1'b0, cfg_reg.sample_period};
            REG_MAX_RELEASE_TIME:   prdata = {1'b0, cfg_reg.max_release_time};
            REG_AVERAGE_SCALE:      prdata = {1'b0, cfg_reg.average_scale};
            default:                prdata = '0;
        endcase
    end

    // input transfer only while the sequencer is idle
    assign samples.ready = in_ready;
    assign in_accept     = samples.valid && in_ready;

    lsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    lsl_datapath #(
        .LOOKAHEAD_LEN (LOOKAHEAD_LEN),
        .WINDOW_LEN    (WINDOW_LEN),
        .HALF_LEN      (HALF_LEN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .in_accept      (in_accept),
        .left_in        (samples.left_in),
        .right_in       (samples.right_in),
        .out_ready      (results.ready),
        .status         (status),
        .out_valid      (results.valid),
        .left_out       (results.left_out),
        .right_out      (results.right_out),
        .fixed_gain     (results.fixed_gain),
        .crest_gain_out (results.crest_gain_out),
        .crest_factor   (results.crest_factor),
        .release_time   (results.release_time),
        .makeup_out     (results.makeup_out)
    );

endmodule

// ===== design/lsl_div.sv =====
module lsl_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lsl_pkg::q31_t num,
    input  lsl_pkg::q31_t den,
    output lsl_pkg::q31_t quo,
    output logic          done
);
    import lsl_pkg::*;

    // restoring divide of (num << 31) by den, one quotient bit a cycle
    localparam logic [4:0] LAST_STEP = 5'd30;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    q31_t        den_reg;
    q31_t        quo_reg;
    logic [31:0] rem_dbl;
    logic        fits;

    assign rem_dbl = {rem_reg[30:0], 1'b0};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                // zero divisor or quotient of one or more saturates
                if (den == '0 || num >= den)
                begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    done_reg <= 1'b0;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= Q31_MAX;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_dbl - {1'b0, den_reg}) : rem_dbl;
            quo_reg <= {quo_reg[29:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== design/lsl_datapath.sv =====
module lsl_datapath #(
    parameter int LOOKAHEAD_LEN = 64,
    parameter int WINDOW_LEN    = 128,
    parameter int HALF_LEN      = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsl_pkg::cfg_t      cfg,
    input  lsl_pkg::cmd_t      cmd,
    input  logic               in_accept,
    input  logic signed [31:0] left_in,
    input  logic signed [31:0] right_in,
    input  logic               out_ready,
    output lsl_pkg::status_t   status,
    output logic               out_valid,
    output logic signed [31:0] left_out,
    output logic signed [31:0] right_out,
    output lsl_pkg::q31_t      fixed_gain,
    output lsl_pkg::q31_t      crest_gain_out,
    output lsl_pkg::q31_t      crest_factor,
    output lsl_pkg::q31_t      release_time,
    output lsl_pkg::q31_t      makeup_out
);
    import lsl_pkg::*;

    localparam int DW = $clog2(LOOKAHEAD_LEN);
    localparam int WW = $clog2(WINDOW_LEN);
    localparam int AW = (HALF_LEN > 1) ? $clog2(HALF_LEN) : 1;
    localparam logic [DW-1:0] D_LAST = DW'(LOOKAHEAD_LEN - 1);
    localparam logic [WW-1:0] W_LAST = WW'(WINDOW_LEN - 1);
    localparam logic [AW-1:0] A_LAST = AW'(HALF_LEN - 1);

    function automatic q31_t mag(input logic [31:0] x);
        logic [31:0] neg;
        neg = -x;
        if (!x[31])
            return x[30:0];
        else if (x == 32'h80000000)
            return Q31_MAX;
        else
            return neg[30:0];
    endfunction

    function automatic q31_t clamp_sum(input logic [31:0] v);
        return v[31] ? '0 : v[30:0];
    endfunction

    function automatic q31_t sat32(input logic [31:0] v);
        return v[31] ? Q31_MAX : v[30:0];
    endfunction

    // memories, filled in order so a fill flag stands for never written
    logic [31:0] delay_l [LOOKAHEAD_LEN];
    logic [31:0] delay_r [LOOKAHEAD_LEN];
    q31_t        window  [WINDOW_LEN];
    logic [31:0] line1   [HALF_LEN];
    logic [31:0] line2   [HALF_LEN];

    // positions and fill flags
    logic [DW-1:0] dp_reg;
    logic [WW-1:0] wp_reg;
    logic [AW-1:0] ap_reg;
    logic          delay_full_reg;
    logic          win_full_reg;
    logic          avg_full_reg;

    // scan engine
    logic          scan_busy_reg;
    logic [WW-1:0] scan_idx_reg;
    logic          rd_v_reg;
    logic          rd_ok_reg;
    logic          rd_last_reg;
    q31_t          win_rd_reg;

    // item payload and intermediates
    logic [31:0] li_reg, ri_reg;
    logic [31:0] dl_rd_reg, dr_rd_reg;
    logic [31:0] l1_rd_reg, l2_rd_reg;
    logic        dvalid_reg, avalid_reg;
    q31_t        peak_reg, gain0_reg, sq_reg, envn_reg, cf_reg, tau_reg, brel_reg;
    logic [62:0] acc_reg;
    logic [31:0] yl_reg, yr_reg;

    // filter state
    logic [31:0] sum1_reg, sum2_reg;
    q31_t        peak_env_reg, rms_env_reg, prev_f_reg, prev_c_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] ol_reg, or_reg;
    q31_t        of_reg, oc_reg, ocf_reg, otau_reg, omk_reg;

    logic [31:0] dl, dr, big, line1_val, line2_val;
    q31_t        gain, sum1_c, new_peak, win_val, stage, hi31, add_sat, tau_sat, rel_val;
    logic [31:0] add_sum, rel_f;
    logic [62:0] rel_sum;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [31:0] mk_sat;
    q31_t        div_num, div_den, div_quo;
    logic        div_done;
    q31_t        rel_prev;

    assign dl        = dvalid_reg ? dl_rd_reg : '0;
    assign dr        = dvalid_reg ? dr_rd_reg : '0;
    assign big       = ($signed(dl) > $signed(dr)) ? dl : dr;
    assign line1_val = avalid_reg ? l1_rd_reg : '0;
    assign line2_val = avalid_reg ? l2_rd_reg : '0;
    assign gain      = clamp_sum(sum2_reg);
    assign sum1_c    = clamp_sum(sum1_reg);
    assign new_peak  = (mag(li_reg) > mag(ri_reg)) ? mag(li_reg) : mag(ri_reg);
    assign win_val   = rd_ok_reg ? win_rd_reg : '0;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_AVG1:
            begin
                mul_a = $signed({2'b00, gain0_reg});
                mul_b = $signed({2'b00, cfg.average_scale});
            end
            OP_AVG2:
            begin
                mul_a = $signed({2'b00, sum1_c});
                mul_b = $signed({2'b00, cfg.average_scale});
            end
            OP_SQ:
            begin
                mul_a = $signed({2'b00, mag(big)});
                mul_b = $signed({2'b00, mag(big)});
            end
            OP_ENV:
            begin
                mul_a = $signed({2'b00, Q31_MAX - cfg.envelope_alpha});
                mul_b = $signed({2'b00, sq_reg});
            end
            OP_PEAK:
            begin
                mul_a = $signed({2'b00, cfg.envelope_alpha});
                mul_b = $signed({2'b00, peak_env_reg});
            end
            OP_RMS:
            begin
                mul_a = $signed({2'b00, cfg.envelope_alpha});
                mul_b = $signed({2'b00, rms_env_reg});
            end
            OP_TAU:
            begin
                mul_a = $signed({1'b0, cfg.max_release_time, 1'b0});
                mul_b = $signed({2'b00, cf_reg});
            end
            OP_FIX_A:
            begin
                mul_a = $signed({2'b00, cfg.fixed_release_coef});
                mul_b = $signed({2'b00, prev_f_reg});
            end
            OP_FIX_B:
            begin
                mul_a = $signed({2'b00, Q31_MAX - cfg.fixed_release_coef});
                mul_b = $signed({2'b00, gain});
            end
            OP_CRS_A:
            begin
                mul_a = $signed({2'b00, Q31_MAX - brel_reg});
                mul_b = $signed({2'b00, prev_c_reg});
            end
            OP_CRS_B:
            begin
                mul_a = $signed({2'b00, brel_reg});
                mul_b = $signed({2'b00, gain});
            end
            OP_OUT_L:
            begin
                mul_a = $signed({dl[31], dl});
                mul_b = $signed({2'b00, prev_c_reg});
            end
            OP_OUT_R:
            begin
                mul_a = $signed({dr[31], dr});
                mul_b = $signed({2'b00, prev_c_reg});
            end
            OP_MK_L:
            begin
                mul_a = $signed({yl_reg[31], yl_reg});
                mul_b = $signed({2'b00, cfg.makeup_gain});
            end
            OP_MK_R:
            begin
                mul_a = $signed({yr_reg[31], yr_reg});
                mul_b = $signed({2'b00, cfg.makeup_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign hi31    = prod[61:31];
    assign stage   = hi31;
    assign add_sum = {1'b0, hi31} + {1'b0, envn_reg};
    assign add_sat = sat32(add_sum);
    assign tau_sat = (|prod[65:47]) ? Q31_MAX : prod[46:16];
    assign rel_sum = acc_reg + prod[62:0];
    assign rel_f   = rel_sum[62:31];
    assign rel_prev = (cmd.op == OP_FIX_B) ? prev_f_reg : prev_c_reg;
    assign rel_val = (gain <= rel_prev) ? gain :
                     ((rel_f < {1'b0, gain}) ? rel_f[30:0] : gain);

    // floor shift by 23 then saturate to the signed 32-bit range
    always_comb
    begin
        if (prod[65:54] == {12{prod[54]}})
            mk_sat = prod[54:23];
        else if (prod[65])
            mk_sat = 32'h80000000;
        else
            mk_sat = 32'h7fffffff;
    end

    always_comb
    begin
        div_num = cfg.threshold;
        div_den = peak_reg;
        case (cmd.div_sel)
            DIV_GAIN:
            begin
                div_num = cfg.threshold;
                div_den = peak_reg;
            end
            DIV_CF:
            begin
                div_num = rms_env_reg;
                div_den = peak_env_reg;
            end
            DIV_REL:
            begin
                div_num = cfg.sample_period;
                div_den = tau_reg;
            end
            default:
            begin
                div_num = cfg.threshold;
                div_den = peak_reg;
            end
        endcase
    end

    lsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // delay line memories, read old pair and write new pair at one slot
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            dl_rd_reg   <= delay_l[dp_reg];
            dr_rd_reg   <= delay_r[dp_reg];
            delay_l[dp_reg] <= li_reg;
            delay_r[dp_reg] <= ri_reg;
        end
    end

    // peak window memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            window[wp_reg] <= new_peak;
        win_rd_reg <= window[scan_idx_reg];
    end

    // moving average lines
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            l1_rd_reg <= line1[ap_reg];
        if (cmd.op == OP_AVG1)
            line1[ap_reg] <= {1'b0, stage};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            l2_rd_reg <= line2[ap_reg];
        if (cmd.op == OP_AVG2)
            line2[ap_reg] <= {1'b0, stage};
    end

    // item payload and intermediates
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            li_reg <= left_in;
            ri_reg <= right_in;
        end
        if (cmd.op == OP_LOAD)
        begin
            dvalid_reg <= delay_full_reg;
            avalid_reg <= avg_full_reg;
        end
        if (cmd.scan_start)
            peak_reg <= '0;
        else if (rd_v_reg && win_val > peak_reg)
            peak_reg <= win_val;
        if (div_done)
        begin
            case (cmd.div_sel)
                DIV_GAIN: gain0_reg <= div_quo;
                DIV_CF:   cf_reg    <= div_quo;
                DIV_REL:  brel_reg  <= div_quo;
                default:  gain0_reg <= div_quo;
            endcase
        end
        case (cmd.op)
            OP_SQ:    sq_reg   <= (big == 32'h80000000) ? Q31_MAX : hi31;
            OP_ENV:   envn_reg <= hi31;
            OP_TAU:   tau_reg  <= tau_sat;
            OP_FIX_A: acc_reg  <= prod[62:0];
            OP_CRS_A: acc_reg  <= prod[62:0];
            OP_OUT_L: yl_reg   <= prod[62:31];
            OP_OUT_R: yr_reg   <= prod[62:31];
            OP_MK_L:  yl_reg   <= mk_sat;
            OP_MK_R:  yr_reg   <= mk_sat;
            default:  ;
        endcase
    end

    // filter state, positions, scan control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg         <= '0;
            wp_reg         <= '0;
            ap_reg         <= '0;
            delay_full_reg <= 1'b0;
            win_full_reg   <= 1'b0;
            avg_full_reg   <= 1'b0;
            scan_busy_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            rd_v_reg       <= 1'b0;
            rd_ok_reg      <= 1'b0;
            rd_last_reg    <= 1'b0;
            sum1_reg       <= '0;
            sum2_reg       <= '0;
            peak_env_reg   <= '0;
            rms_env_reg    <= '0;
            prev_f_reg     <= Q31_MAX;
            prev_c_reg     <= Q31_MAX;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg    <= scan_busy_reg;
            rd_ok_reg   <= win_full_reg || (scan_idx_reg <= wp_reg);
            rd_last_reg <= scan_busy_reg && (scan_idx_reg == W_LAST);
            if (cmd.scan_start)
            begin
                scan_busy_reg <= 1'b1;
                scan_idx_reg  <= '0;
            end
            else if (scan_busy_reg)
            begin
                if (scan_idx_reg == W_LAST)
                    scan_busy_reg <= 1'b0;
                else
                    scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            // a new result replaces one that is leaving in the same cycle
            if (cmd.op == OP_PUBLISH)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                OP_AVG1: sum1_reg <= sum1_reg + {1'b0, stage} - line1_val;
                OP_AVG2: sum2_reg <= sum2_reg + {1'b0, stage} - line2_val;
                OP_PEAK: peak_env_reg <= (add_sat > sq_reg) ? add_sat : sq_reg;
                OP_RMS:  rms_env_reg  <= add_sat;
                OP_FIX_B: prev_f_reg  <= rel_val;
                OP_CRS_B: prev_c_reg  <= rel_val;
                OP_PUBLISH:
                begin
                    dp_reg <= (dp_reg == D_LAST) ? '0 : dp_reg + 1'b1;
                    wp_reg <= (wp_reg == W_LAST) ? '0 : wp_reg + 1'b1;
                    ap_reg <= (ap_reg == A_LAST) ? '0 : ap_reg + 1'b1;
                    if (dp_reg == D_LAST)
                        delay_full_reg <= 1'b1;
                    if (wp_reg == W_LAST)
                        win_full_reg <= 1'b1;
                    if (ap_reg == A_LAST)
                        avg_full_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUBLISH)
        begin
            ol_reg   <= yl_reg;
            or_reg   <= yr_reg;
            of_reg   <= prev_f_reg;
            oc_reg   <= prev_c_reg;
            ocf_reg  <= cf_reg;
            otau_reg <= tau_reg;
            omk_reg  <= cfg.makeup_gain;
        end
    end

    assign status.scan_done = rd_last_reg;
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign left_out       = ol_reg;
    assign right_out      = or_reg;
    assign fixed_gain     = of_reg;
    assign crest_gain_out = oc_reg;
    assign crest_factor   = ocf_reg;
    assign release_time   = otau_reg;
    assign makeup_out     = omk_reg;

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_PUBLISH |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_PUBLISH |=> out_valid_reg)
        else $error("published result not shown");

    a_scan_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |-> !scan_busy_reg)
        else $error("window written during scan");

endmodule

// ===== design/lsl_ctrl.sv =====
module lsl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lsl_pkg::status_t status,
    output logic             in_ready,
    output lsl_pkg::cmd_t    cmd
);
    import lsl_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN_GO,
        ST_SCAN_WAIT,
        ST_DIVG_GO,
        ST_DIVG_WAIT,
        ST_AVG1,
        ST_AVG2,
        ST_SQ,
        ST_ENV,
        ST_PEAK,
        ST_RMS,
        ST_DIVC_GO,
        ST_DIVC_WAIT,
        ST_TAU,
        ST_DIVR_GO,
        ST_DIVR_WAIT,
        ST_FIX_A,
        ST_FIX_B,
        ST_CRS_A,
        ST_CRS_B,
        ST_OUT_L,
        ST_OUT_R,
        ST_MK_L,
        ST_MK_R,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_LOAD;
            ST_LOAD:      state_next = ST_SCAN_GO;
            ST_SCAN_GO:   state_next = ST_SCAN_WAIT;
            ST_SCAN_WAIT: if (status.scan_done) state_next = ST_DIVG_GO;
            ST_DIVG_GO:   state_next = ST_DIVG_WAIT;
            ST_DIVG_WAIT: if (status.div_done) state_next = ST_AVG1;
            ST_AVG1:      state_next = ST_AVG2;
            ST_AVG2:      state_next = ST_SQ;
            ST_SQ:        state_next = ST_ENV;
            ST_ENV:       state_next = ST_PEAK;
            ST_PEAK:      state_next = ST_RMS;
            ST_RMS:       state_next = ST_DIVC_GO;
            ST_DIVC_GO:   state_next = ST_DIVC_WAIT;
            ST_DIVC_WAIT: if (status.div_done) state_next = ST_TAU;
            ST_TAU:       state_next = ST_DIVR_GO;
            ST_DIVR_GO:   state_next = ST_DIVR_WAIT;
            ST_DIVR_WAIT: if (status.div_done) state_next = ST_FIX_A;
            ST_FIX_A:     state_next = ST_FIX_B;
            ST_FIX_B:     state_next = ST_CRS_A;
            ST_CRS_A:     state_next = ST_CRS_B;
            ST_CRS_B:     state_next = ST_OUT_L;
            ST_OUT_L:     state_next = ST_OUT_R;
            ST_OUT_R:     state_next = ST_MK_L;
            ST_MK_L:      state_next = ST_MK_R;
            ST_MK_R:      state_next = ST_FINISH;
            ST_FINISH:    if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op         = OP_NONE;
        cmd.div_sel    = DIV_GAIN;
        cmd.div_start  = 1'b0;
        cmd.scan_start = 1'b0;
        case (state_reg)
            ST_LOAD:      cmd.op = OP_LOAD;
            ST_SCAN_GO:   cmd.scan_start = 1'b1;
            ST_DIVG_GO:   begin cmd.div_sel = DIV_GAIN; cmd.div_start = 1'b1; end
            ST_DIVG_WAIT: cmd.div_sel = DIV_GAIN;
            ST_AVG1:      cmd.op = OP_AVG1;
            ST_AVG2:      cmd.op = OP_AVG2;
            ST_SQ:        cmd.op = OP_SQ;
            ST_ENV:       cmd.op = OP_ENV;
            ST_PEAK:      cmd.op = OP_PEAK;
            ST_RMS:       cmd.op = OP_RMS;
            ST_DIVC_GO:   begin cmd.div_sel = DIV_CF; cmd.div_start = 1'b1; end
            ST_DIVC_WAIT: cmd.div_sel = DIV_CF;
            ST_TAU:       cmd.op = OP_TAU;
            ST_DIVR_GO:   begin cmd.div_sel = DIV_REL; cmd.div_start = 1'b1; end
            ST_DIVR_WAIT: cmd.div_sel = DIV_REL;
            ST_FIX_A:     cmd.op = OP_FIX_A;
            ST_FIX_B:     cmd.op = OP_FIX_B;
            ST_CRS_A:     cmd.op = OP_CRS_A;
            ST_CRS_B:     cmd.op = OP_CRS_B;
            ST_OUT_L:     cmd.op = OP_OUT_L;
            ST_OUT_R:     cmd.op = OP_OUT_R;
            ST_MK_L:      cmd.op = OP_MK_L;
            ST_MK_R:      cmd.op = OP_MK_R;
            ST_FINISH:    if (status.out_free) cmd.op = OP_PUBLISH;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIVG_WAIT || state_reg == ST_DIVC_WAIT
                             || state_reg == ST_DIVR_WAIT))
        else $error("divider finished outside a wait state");

    a_scan_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.scan_done |-> state_reg == ST_SCAN_WAIT)
        else $error("scan finished outside its wait state");

endmodule

// ===== bench/tb_lookahead_stereo_limiter.sv =====
module tb_lookahead_stereo_limiter;
    import lsl_pkg::*;

    localparam int DELAY_DEPTH  = 64;
    localparam int WINDOW_DEPTH = 128;
    localparam int AVG_DEPTH    = 32;
    localparam int N_REGS       = 7;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 525;
    localparam int N_PHASES      = 7;

    typedef struct {
        logic signed [31:0] left;
        logic signed [31:0] right;
        q31_t               fixed_gain;
        q31_t               adaptive_gain;
        q31_t               crest_factor;
        q31_t               release_time;
        q31_t               makeup;
        bit                 typed;   // delayed-zero output known by hand
    } limiter_result_t;

    typedef struct {
        logic signed [31:0] left;
        logic signed [31:0] right;
        bit                 typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lsl_in_if  samples ();
    lsl_out_if results ();

    lookahead_stereo_limiter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples),
        .results (results)
    );

    // model copy of the register file
    q31_t cfg_regs [N_REGS];

    // model copy of the datapath state
    bit [31:0] delay_l [DELAY_DEPTH];
    bit [31:0] delay_r [DELAY_DEPTH];
    bit [31:0] peak_hold [WINDOW_DEPTH];
    bit [31:0] ma_line_one [AVG_DEPTH];
    bit [31:0] ma_line_two [AVG_DEPTH];
    bit [31:0] ma_sum_one, ma_sum_two;
    bit [31:0] last_fixed_gain, last_adaptive_gain, peak_track, rms_track;
    int        delay_idx, window_idx, avg_idx;

    limiter_result_t pending_results [$];
    int              mismatch_count;
    bit              next_typed;

    stim_row_t directed_rows [] = '{
        '{32'sh00000000, 32'sh00000000, 1'b1},
        '{32'sh80000000, 32'sh80000000, 1'b1},
        '{32'sh7fffffff, 32'sh7fffffff, 1'b1},
        '{32'sh80000000, 32'sh7fffffff, 1'b1},
        '{32'sh7fffffff, 32'sh80000000, 1'b1},
        '{32'shffffffff, 32'sh00000001, 1'b1},
        '{32'sh00000001, 32'shffffffff, 1'b1},
        '{32'sh00000000, 32'sh80000000, 1'b1},
        '{32'sh10000000, 32'shc0000000, 1'b1},
        '{32'shc0000000, 32'sh10000000, 1'b1},
        '{32'sh0ccccccd, 32'sh0ccccccd, 1'b1},
        '{32'sh0ccccccc, 32'shf3333334, 1'b1},
        '{32'sh40000000, 32'sh00000000, 1'b1},
        '{32'sh00000000, 32'sh00000000, 1'b1},
        '{32'sh00000000, 32'sh00000000, 1'b1},
        '{32'sh55555555, 32'shaaaaaaaa, 1'b1},
        '{32'shaaaaaaaa, 32'sh55555555, 1'b1},
        '{32'sh00010000, 32'shfff00000, 1'b1},
        '{32'sh7ffffffe, 32'sh80000001, 1'b1},
        '{32'sh01000000, 32'sh02000000, 1'b1},
        '{32'shfe000000, 32'shff000000, 1'b1},
        '{32'sh00000000, 32'sh00000000, 1'b1},
        '{32'sh00000000, 32'sh00000000, 1'b1},
        '{32'sh20000000, 32'sh20000000, 1'b1},
        '{32'sh80000000, 32'sh00000000, 1'b1}
    };

    // free-running clock, period 10
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit [31:0] sat31(bit [63:0] v);
        return (v > 64'(Q31_MAX)) ? 32'(Q31_MAX) : v[31:0];
    endfunction

    function automatic bit [31:0] clamp_pos(bit [31:0] v);
        return v[31] ? 32'd0 : v;
    endfunction

    // magnitude with the full-scale negative value pinned to q31 max
    function automatic bit [31:0] magnitude(int x);
        if (x >= 0)
            return 32'(x);
        if (x == 32'sh80000000)
            return 32'(Q31_MAX);
        return 32'(-x);
    endfunction

    function automatic bit [31:0] q31_div(bit [31:0] num, bit [31:0] den);
        if (den == 0)
            return 32'(Q31_MAX);
        return sat31(({32'd0, num} << 31) / {32'd0, den});
    endfunction

    function automatic bit [31:0] q31_mul(bit [31:0] a, bit [31:0] b);
        bit [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return 32'(p >> 31);
    endfunction

    function automatic int sat_s32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    // one-pole release: attack is instant, release pulls toward the new gain
    function automatic bit [31:0] release_filter(bit [31:0] g, bit [31:0] prev, bit [31:0] a);
        bit [63:0] t;
        bit [31:0] f;
        if (g <= prev)
            return g;
        t = {32'd0, a} * {32'd0, prev} + {32'd0, 32'(Q31_MAX) - a} * {32'd0, g};
        f = 32'(t >> 31);
        return (f < g) ? f : g;
    endfunction

    task automatic clear_limiter_state();
        for (int i = 0; i < DELAY_DEPTH; i++)
        begin
            delay_l[i] = 0;
            delay_r[i] = 0;
        end
        for (int i = 0; i < WINDOW_DEPTH; i++)
            peak_hold[i] = 0;
        for (int i = 0; i < AVG_DEPTH; i++)
        begin
            ma_line_one[i] = 0;
            ma_line_two[i] = 0;
        end
        ma_sum_one         = 0;
        ma_sum_two         = 0;
        last_fixed_gain    = 32'(Q31_MAX);
        last_adaptive_gain = 32'(Q31_MAX);
        peak_track         = 0;
        rms_track          = 0;
        delay_idx          = 0;
        window_idx         = 0;
        avg_idx            = 0;
        cfg_regs[REG_THRESHOLD]          = RST_THRESHOLD;
        cfg_regs[REG_MAKEUP_GAIN]        = RST_MAKEUP_GAIN;
        cfg_regs[REG_FIXED_RELEASE_COEF] = RST_FIXED_RELEASE_COEF;
        cfg_regs[REG_ENVELOPE_ALPHA]     = RST_ENVELOPE_ALPHA;
        cfg_regs[REG_SAMPLE_PERIOD]      = RST_SAMPLE_PERIOD;
        cfg_regs[REG_MAX_RELEASE_TIME]   = RST_MAX_RELEASE_TIME;
        cfg_regs[REG_AVERAGE_SCALE]      = RST_AVERAGE_SCALE;
    endtask

    // advance the limiter model by one stereo pair and queue its result
    task automatic limit_pair(bit [31:0] li, bit [31:0] ri, bit typed);
        int        dl, dr, big;
        bit [31:0] ml, mr, peak, gain, stage, sq, env_new, pk, cf, tau, b_rel;
        bit [31:0] fixed_g, crest_g, alpha, makeup;
        longint    yl, yr;
        limiter_result_t res;

        alpha  = 32'(cfg_regs[REG_ENVELOPE_ALPHA]);
        makeup = 32'(cfg_regs[REG_MAKEUP_GAIN]);

        dl = int'(delay_l[delay_idx]);
        dr = int'(delay_r[delay_idx]);
        delay_l[delay_idx] = li;
        delay_r[delay_idx] = ri;

        ml = magnitude(int'(li));
        mr = magnitude(int'(ri));
        peak_hold[window_idx] = (ml > mr) ? ml : mr;
        peak = 0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
            if (peak_hold[i] > peak)
                peak = peak_hold[i];

        gain = q31_div(32'(cfg_regs[REG_THRESHOLD]), peak);

        // two cascaded moving averages, sums wrap at 32 bits
        stage = q31_mul(gain, 32'(cfg_regs[REG_AVERAGE_SCALE]));
        ma_sum_one = ma_sum_one + stage - ma_line_one[avg_idx];
        ma_line_one[avg_idx] = stage;
        stage = q31_mul(clamp_pos(ma_sum_one), 32'(cfg_regs[REG_AVERAGE_SCALE]));
        ma_sum_two = ma_sum_two + stage - ma_line_two[avg_idx];
        ma_line_two[avg_idx] = stage;
        gain = clamp_pos(ma_sum_two);

        // trackers take the signed-larger delayed sample
        big = (dl > dr) ? dl : dr;
        sq = sat31(({32'd0, magnitude(big)} * {32'd0, magnitude(big)}) >> 31);
        if (big == 32'sh80000000)
            sq = 32'(Q31_MAX);
        env_new    = q31_mul(32'(Q31_MAX) - alpha, sq);
        pk         = sat31(64'(q31_mul(alpha, peak_track)) + 64'(env_new));
        peak_track = (pk > sq) ? pk : sq;
        rms_track  = sat31(64'(q31_mul(alpha, rms_track)) + 64'(env_new));
        cf         = q31_div(rms_track, peak_track);

        tau   = sat31(((64'(cfg_regs[REG_MAX_RELEASE_TIME]) << 1) * 64'(cf)) >> 16);
        b_rel = q31_div(32'(cfg_regs[REG_SAMPLE_PERIOD]), tau);

        fixed_g = release_filter(gain, last_fixed_gain, 32'(cfg_regs[REG_FIXED_RELEASE_COEF]));
        last_fixed_gain = fixed_g;
        crest_g = release_filter(gain, last_adaptive_gain, 32'(Q31_MAX) - b_rel);
        last_adaptive_gain = crest_g;

        // arithmetic shift of a signed product rounds toward minus infinity
        yl = (longint'(dl) * longint'(crest_g)) >>> 31;
        yr = (longint'(dr) * longint'(crest_g)) >>> 31;
        yl = (yl * longint'(makeup)) >>> 23;
        yr = (yr * longint'(makeup)) >>> 23;

        delay_idx  = (delay_idx + 1) % DELAY_DEPTH;
        window_idx = (window_idx + 1) % WINDOW_DEPTH;
        avg_idx    = (avg_idx + 1) % AVG_DEPTH;

        res.left          = sat_s32(yl);
        res.right         = sat_s32(yr);
        res.fixed_gain    = fixed_g[30:0];
        res.adaptive_gain = crest_g[30:0];
        res.crest_factor  = cf[30:0];
        res.release_time  = tau[30:0];
        res.makeup        = makeup[30:0];
        res.typed         = typed;
        pending_results.push_back(res);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h at %0t",
                         name, want, got, $realtime);
        end
    endtask

    // input transfers feed the model
    always @(posedge clk)
    begin
        if (rst_n && samples.valid && samples.ready)
            limit_pair(samples.left_in, samples.right_in, next_typed);
    end

    // output transfers are checked against the oldest prediction
    always @(posedge clk)
    begin
        limiter_result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer at %0t", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.typed)
                begin
                    // lookahead line still holds reset zeros
                    check_field("left_out fill", 32'd0, results.left_out);
                    check_field("right_out fill", 32'd0, results.right_out);
                end
                check_field("left_out", want.left, results.left_out);
                check_field("right_out", want.right, results.right_out);
                check_field("fixed_gain", {1'b0, want.fixed_gain}, {1'b0, results.fixed_gain});
                check_field("crest_gain_out", {1'b0, want.adaptive_gain},
                            {1'b0, results.crest_gain_out});
                check_field("crest_factor", {1'b0, want.crest_factor},
                            {1'b0, results.crest_factor});
                check_field("release_time", {1'b0, want.release_time},
                            {1'b0, results.release_time});
                check_field("makeup_out", {1'b0, want.makeup}, {1'b0, results.makeup_out});
            end
        end
    end

    // result-side back-pressure: random holds, mostly short, a few long
    int ready_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            ready_hold    <= 0;
        end
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            results.ready <= ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 9) < 8)
                ready_hold <= $urandom_range(0, 3);
            else
                ready_hold <= $urandom_range(10, 300);
        end
    end

    // apb write: setup then access, the register takes it at the access edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_regs[idx] = value[30:0];
    endtask

    // one sample transfer; valid stays high when the next item follows at once
    task automatic send_pair(logic [31:0] l, logic [31:0] r, bit typed);
        int gap;
        samples.valid    <= 1'b1;
        samples.left_in  <= l;
        samples.right_in <= r;
        do
            @(negedge clk);
        while (!samples.ready);
        next_typed = typed;
        @(posedge clk);
        if ($urandom_range(0, 2) == 0)
        begin
            samples.valid <= 1'b0;
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                             : $urandom_range(20, 400);
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for all predicted results, then let the pipeline settle
    task automatic drain();
        @(posedge clk);
        samples.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_sample(int style);
        case (style)
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h80000000;
                    1: return 32'h7fffffff;
                    2: return 32'h00000000;
                    3: return 32'hffffffff;
                    default: return 32'h00000001;
                endcase
            end
            1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            2: return $urandom;
            default: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] random_reg(int phase, int idx);
        case (phase)
            1: return {1'b1, Q31_MAX};
            2: return 32'd0;
            3: return (idx == REG_AVERAGE_SCALE || idx == REG_THRESHOLD)
                      ? 32'h7fffffff : $urandom;
            4: return (idx == REG_MAKEUP_GAIN) ? 32'h7fffffff : 32'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int style;
        int burst;
        int per_phase;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        samples.valid    = 1'b0;
        samples.left_in  = '0;
        samples.right_in = '0;
        mismatch_count   = 0;
        next_typed       = 1'b0;
        clear_limiter_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows at reset settings
        foreach (directed_rows[i])
            send_pair(directed_rows[i].left, directed_rows[i].right, directed_rows[i].typed);
        drain();

        // random phases, each under a new register setting
        per_phase = RANDOM_ITEMS / N_PHASES;
        for (int phase = 1; phase <= N_PHASES; phase++)
        begin
            if (phase == N_PHASES)
            begin
                write_reg(REG_THRESHOLD, RST_THRESHOLD);
                write_reg(REG_MAKEUP_GAIN, RST_MAKEUP_GAIN);
                write_reg(REG_FIXED_RELEASE_COEF, RST_FIXED_RELEASE_COEF);
                write_reg(REG_ENVELOPE_ALPHA, RST_ENVELOPE_ALPHA);
                write_reg(REG_SAMPLE_PERIOD, RST_SAMPLE_PERIOD);
                write_reg(REG_MAX_RELEASE_TIME, RST_MAX_RELEASE_TIME);
                write_reg(REG_AVERAGE_SCALE, RST_AVERAGE_SCALE);
            end
            else
                for (int r = 0; r < N_REGS; r++)
                    write_reg(3'(r), random_reg(phase, r));
            burst = 0;
            style = 2;
            for (int n = 0; n < per_phase; n++)
            begin
                // runs of one signal style so the window and trackers settle
                if (burst == 0)
                begin
                    style = $urandom_range(0, 3);
                    burst = $urandom_range(1, 40);
                end
                burst--;
                send_pair(random_sample(style), random_sample(style), 1'b0);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #60000000;
        $display("simulation failed");
        $finish;
    end

endmodule
